/* design/rc5_pkg.sv */
// ---------------------------------------------------------------------------
// rc5_pkg
// shared constants, types and helpers for the rc5 block cipher core
// ---------------------------------------------------------------------------
package rc5_pkg;

    localparam int unsigned ROUND_COUNT_DEF = 12;
    localparam int unsigned KEY_LENGTH_DEF  = 16;

    localparam logic [31:0] MAGIC_P = 32'hb7e15163;
    localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_MIX,
        S_ENC
    } t_state;

    // per-cycle control of one ring cell
    typedef struct packed {
        logic load;
        logic shift1;
        logic shift2;
    } t_cell_ctrl;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

endpackage

/* design/rc5_block_encrypt.sv */
// ---------------------------------------------------------------------------
// rc5_block_encrypt
// rc5-32 block encryption with key schedule held in a ring of cells
// ---------------------------------------------------------------------------
// a word is accepted only in idle; it then gets the initial subkey add and the rounds,
// and the last round lands in the output register, held back while a result is pending
// after reset or a key write the first word first runs key expansion, a table load
// and then the mixing steps, one mixing step per cycle
// reset is synchronous active low and clears control, the key registers and the table ready flag
module rc5_block_encrypt #(
    parameter int unsigned ROUND_COUNT = rc5_pkg::ROUND_COUNT_DEF,
    parameter int unsigned KEY_LENGTH  = rc5_pkg::KEY_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word_a,
    input  logic [31:0] i_word_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_cipher_a,
    output logic [31:0] o_cipher_b
);

    localparam int unsigned TD   = 2 * ROUND_COUNT + 2;
    localparam int unsigned KW   = (KEY_LENGTH + 3) / 4;
    localparam int unsigned MIXN = 3 * TD;
    localparam int unsigned CW   = $clog2(MIXN + 1);
    localparam logic [7:0]  IDX_KEY_LOW  = 8'd0;
    localparam logic [7:0]  IDX_KEY_HIGH = 8'd1;

    rc5_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_tab_ok, n_tab_ok;
    logic [63:0]     r_key_low, r_key_high;
    logic [31:0]     r_a, n_a, r_b, n_b;
    logic [31:0]     r_ma, n_ma, r_mb, n_mb;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_out_a, r_out_b;
    logic            out_load;

    rc5_pkg::t_cell_ctrl s_ctrl, l_ctrl;
    logic [31:0] s_q [TD];
    logic [31:0] l_q [KW];
    logic [127:0] key_all;
    logic [31:0] mix_a, mix_b, mix_sum;
    logic [31:0] rnd_a, rnd_b;

    assign key_all = {r_key_high, r_key_low};

    // mixing step on the ring heads
    assign mix_a   = rc5_pkg::rotl32(s_q[0] + r_ma + r_mb, 5'd3);
    assign mix_sum = mix_a + r_mb;
    assign mix_b   = rc5_pkg::rotl32(l_q[0] + mix_sum, mix_sum[4:0]);

    // one round with the two head subkeys
    assign rnd_a = rc5_pkg::rotl32(r_a ^ r_b, r_b[4:0]) + s_q[0];
    assign rnd_b = rc5_pkg::rotl32(r_b ^ rnd_a, rnd_a[4:0]) + s_q[1];

    genvar k;
    generate
        for (k = 0; k < TD; k++) begin : g_sub
            localparam logic [31:0] INIT = rc5_pkg::MAGIC_P + 32'(k) * rc5_pkg::MAGIC_Q;
            logic [31:0] d1;
            if (k == TD - 1) begin : g_tail
                assign d1 = mix_a;
            end else begin : g_body
                assign d1 = s_q[k + 1];
            end
            rc5_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (s_ctrl),
                .i_load_val(INIT),
                .i_d1      (d1),
                .i_d2      (s_q[(k + 2) % TD]),
                .o_q       (s_q[k])
            );
        end
        for (k = 0; k < KW; k++) begin : g_key
            logic [31:0] d1;
            logic [31:0] init;
            genvar m;
            for (m = 0; m < 4; m++) begin : g_byte
                if (4 * k + m < KEY_LENGTH) begin : g_use
                    assign init[8*m +: 8] = key_all[8*(4*k+m) +: 8];
                end else begin : g_pad
                    assign init[8*m +: 8] = 8'h00;
                end
            end
            if (k == KW - 1) begin : g_tail
                assign d1 = mix_b;
            end else begin : g_body
                assign d1 = l_q[k + 1];
            end
            rc5_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (l_ctrl),
                .i_load_val(init),
                .i_d1      (d1),
                .i_d2      (l_q[k]),
                .o_q       (l_q[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc5_pkg::S_IDLE;
            r_cnt       <= '0;
            r_tab_ok    <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_low   <= '0;
            r_key_high  <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tab_ok    <= n_tab_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == IDX_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == IDX_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_b  <= n_b;
        r_ma <= n_ma;
        r_mb <= n_mb;
        if (out_load) begin
            r_out_a <= rnd_a;
            r_out_b <= rnd_b;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tab_ok    = r_tab_ok;
        n_a         = r_a;
        n_b         = r_b;
        n_ma        = r_ma;
        n_mb        = r_mb;
        s_ctrl      = '0;
        l_ctrl      = '0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = (r_state == rc5_pkg::S_IDLE);
        case (r_state)
            rc5_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_a   = i_word_a;
                    n_b   = i_word_b;
                    n_cnt = '0;
                    n_state = r_tab_ok ? rc5_pkg::S_ENC : rc5_pkg::S_INIT;
                end
            end
            rc5_pkg::S_INIT: begin
                s_ctrl.load = 1'b1;
                l_ctrl.load = 1'b1;
                n_ma        = '0;
                n_mb        = '0;
                n_state     = rc5_pkg::S_MIX;
            end
            rc5_pkg::S_MIX: begin
                s_ctrl.shift1 = 1'b1;
                l_ctrl.shift1 = 1'b1;
                n_ma          = mix_a;
                n_mb          = mix_b;
                if (r_cnt == CW'(MIXN - 1)) begin
                    n_tab_ok = 1'b1;
                    n_cnt    = '0;
                    n_state  = rc5_pkg::S_ENC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rc5_pkg::S_ENC: begin
                if (r_cnt == '0) begin
                    // initial subkey add
                    n_a = r_a + s_q[0];
                    n_b = r_b + s_q[1];
                    s_ctrl.shift2 = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else if (r_cnt != CW'(ROUND_COUNT)) begin
                    n_a = rnd_a;
                    n_b = rnd_b;
                    s_ctrl.shift2 = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else if (!(r_out_valid && !i_ready)) begin
                    // last round lands in the output register
                    s_ctrl.shift2 = 1'b1;
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = rc5_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rc5_pkg::S_IDLE;
            end
        endcase
        // a key write drops the expanded table
        if (i_cfg_we && (i_cfg_idx == IDX_KEY_LOW || i_cfg_idx == IDX_KEY_HIGH)) begin
            n_tab_ok = 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_cipher_a = r_out_a;
    assign o_cipher_b = r_out_b;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != rc5_pkg::S_IDLE))
        else $error("accepted word left block idle");

    a_result_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_tab_ok && r_state == rc5_pkg::S_ENC))
        else $error("result produced without expanded table");

    a_key_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == IDX_KEY_LOW || i_cfg_idx == IDX_KEY_HIGH))
        |=> !r_tab_ok)
        else $error("key write kept stale table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cipher_a) && $stable(o_cipher_b)))
        else $error("pending result overwritten");

endmodule

/* design/rc5_cell.sv */
// ---------------------------------------------------------------------------
// rc5_cell
// one word of a rotating table; loads, holds or takes a neighbor's word
// ---------------------------------------------------------------------------
module rc5_cell (
    input  logic                i_clk,
    input  rc5_pkg::t_cell_ctrl i_ctrl,
    input  logic [31:0]         i_load_val,
    input  logic [31:0]         i_d1,
    input  logic [31:0]         i_d2,
    output logic [31:0]         o_q
);

    logic [31:0] r_q;
    logic [31:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctrl.load) begin
            n_q = i_load_val;
        end else if (i_ctrl.shift2) begin
            n_q = i_d2;
        end else if (i_ctrl.shift1) begin
            n_q = i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

/* dv/tb_rc5_block_encrypt.sv */
// ---------------------------------------------------------------------------
// tb_rc5_block_encrypt
// drives plaintext words through the rc5 core under several keys, predicts
// each ciphertext word with an own key schedule and round loop, and checks
// results in order under random sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module tb_rc5_block_encrypt;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROUNDS   = rc5_pkg::ROUND_COUNT_DEF;
    localparam int unsigned KEY_LEN  = rc5_pkg::KEY_LENGTH_DEF;
    localparam int unsigned SUBKEYS  = 2 * ROUNDS + 2;
    localparam int unsigned KWORDS   = (KEY_LEN + 3) / 4;
    localparam int unsigned MIXES    = 3 * (SUBKEYS > KWORDS ? SUBKEYS : KWORDS);
    localparam logic [7:0]  IDX_KEY_LOW  = 8'd0;
    localparam logic [7:0]  IDX_KEY_HIGH = 8'd1;
    localparam logic [7:0]  IDX_UNUSED   = 8'd2;
    localparam int          CYCLE_LIMIT  = 900000;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_block;

    // ciphertext predictor with its own copy of the key and schedule
    class cipher_scoreboard;
        logic [63:0] key_lo, key_hi;
        logic [31:0] sched [SUBKEYS];
        bit          sched_valid;
        t_block      pending [$];
        int          errors, checked;

        function new();
            key_lo = '0; key_hi = '0; sched_valid = 0; errors = 0; checked = 0;
        endfunction

        function void write_key(logic [7:0] idx, logic [63:0] val);
            if (idx == IDX_KEY_LOW) begin
                key_lo = val; sched_valid = 0;
            end else if (idx == IDX_KEY_HIGH) begin
                key_hi = val; sched_valid = 0;
            end
        endfunction

        function logic [31:0] rol(logic [31:0] x, logic [31:0] n);
            logic [4:0] s;
            s = n[4:0];
            return (s == 0) ? x : ((x << s) | (x >> (6'd32 - s)));
        endfunction

        function void build_schedule();
            logic [31:0] kw [4];
            logic [31:0] x, y;
            logic [7:0]  by;
            int i, j;
            for (int k = 0; k < 4; k++) kw[k] = '0;
            for (int k = KEY_LEN - 1; k >= 0; k--) begin
                by = (k < 8) ? key_lo[8*(k%8) +: 8] : key_hi[8*(k%8) +: 8];
                kw[(k/4)%4] = (kw[(k/4)%4] << 8) + by;
            end
            sched[0] = rc5_pkg::MAGIC_P;
            for (int k = 1; k < SUBKEYS; k++) sched[k] = sched[k-1] + rc5_pkg::MAGIC_Q;
            x = '0; y = '0; i = 0; j = 0;
            for (int st = 0; st < MIXES; st++) begin
                x = rol(sched[i] + x + y, 3);
                sched[i] = x;
                y = rol(kw[j] + x + y, x + y);
                kw[j] = y;
                i = (i + 1) % SUBKEYS;
                j = (j + 1) % KWORDS;
            end
            sched_valid = 1;
        endfunction

        function void note_input(logic [31:0] pa, logic [31:0] pb);
            t_block e;
            if (!sched_valid) build_schedule();
            e.a = pa + sched[0];
            e.b = pb + sched[1];
            for (int r = 1; r <= ROUNDS; r++) begin
                e.a = rol(e.a ^ e.b, e.b) + sched[2*r];
                e.b = rol(e.b ^ e.a, e.a) + sched[2*r+1];
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(logic [31:0] ca, logic [31:0] cb);
            t_block e;
            if (pending.size() == 0) begin
                $error("unexpected word: cipher_a %h cipher_b %h", ca, cb);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (ca !== e.a) begin
                $error("cipher_a expected %h actual %h", e.a, ca); errors++;
            end
            if (cb !== e.b) begin
                $error("cipher_b expected %h actual %h", e.b, cb); errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid, o_ready;
    logic [31:0] i_word_a, i_word_b;
    logic        o_valid, i_ready;
    logic [31:0] o_cipher_a, o_cipher_b;

    cipher_scoreboard sb;
    int  cycles;
    int  sent;
    int  stall_mode;

    rc5_block_encrypt i_dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // output monitor and receiver stall pattern
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_cipher_a, o_cipher_b);
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= cycles[3];
        endcase
    end

    always @(posedge i_clk) if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);

    initial begin
        cycles = 0;
        stall_mode = 0;
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 0; i_word_a = '0; i_word_b = '0; i_ready = 0;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("rc5_block_encrypt test failed");
        $finish;
    end

    task automatic write_reg(logic [7:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_key(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // holds the word until accepted; with keep set leaves valid high for back to back sends
    task automatic send_word(logic [31:0] pa, logic [31:0] pb, bit keep);
        @(negedge i_clk);
        i_valid <= 1; i_word_a <= pa; i_word_b <= pb;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(pa, pb);
        sent++;
        if (!keep) begin
            @(negedge i_clk);
            i_valid <= 0;
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (ROUNDS + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst, gap;
        bit keep;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n > 0; k++) begin
                n--;
                keep = (k < burst - 1) && (n > 0);
                send_word(rand_word(), rand_word(), keep);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    logic [63:0] keys [6][2];

    initial begin
        sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // reset key of all zero
        send_word(32'h0, 32'h0, 0);
        send_word(32'hffffffff, 32'hffffffff, 0);
        send_word(32'h0, 32'hffffffff, 1);
        send_word(32'hffffffff, 32'h0, 0);
        drain();
        write_reg(IDX_KEY_LOW, 64'hffffffffffffffff);
        write_reg(IDX_KEY_HIGH, 64'hffffffffffffffff);
        for (int k = 0; k < 8; k++) send_word(32'h1 << (k * 4), ~(32'h1 << (k * 3)), k < 7);
        drain();
        // ignored index must leave the schedule alone
        write_reg(IDX_UNUSED, 64'h0123456789abcdef);
        send_word(32'h12345678, 32'h9abcdef0, 0);
        drain();
        // key change on one register only
        write_reg(IDX_KEY_HIGH, 64'h0);
        send_word(32'h12345678, 32'h9abcdef0, 0);
        send_word(32'h80000000, 32'h00000001, 0);
        drain();

        keys[0] = '{64'h0, 64'h0};
        keys[1] = '{64'hffffffffffffffff, 64'hffffffffffffffff};
        keys[2] = '{64'h0706050403020100, 64'h0f0e0d0c0b0a0908};
        keys[3] = '{{$urandom(), $urandom()}, {$urandom(), $urandom()}};
        keys[4] = '{{$urandom(), $urandom()}, 64'h0};
        keys[5] = '{{$urandom(), $urandom()}, {$urandom(), $urandom()}};
        for (int p = 0; p < 6; p++) begin
            write_reg(IDX_KEY_LOW, keys[p][0]);
            write_reg(IDX_KEY_HIGH, keys[p][1]);
            random_phase(305);
            drain();
        end

        $display("covered %0d words under %0d key settings, %0d results checked",
                 sent, 9, sb.checked);
        if (sb.errors == 0) $display("rc5_block_encrypt test passed");
        else $display("rc5_block_encrypt test failed");
        $finish;
    end
endmodule
